// File: hdl/limit_seek_stepper_sequencer_defines.svh
// Assertion macros for the limit-seek stepper sequencer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LIMIT_SEEK_STEPPER_SEQUENCER_DEFINES_SVH
`define LIMIT_SEEK_STEPPER_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lss check failed");
// next-cycle implication
`define LSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lss check failed");
`else
`define LSS_ASSERT_NOW(label, clk, rst, ante, cons)
`define LSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/lss_pkg.sv
// Shared types and constants for the limit-seek stepper sequencer.
// No dependencies; imported by every module of the block.
package lss_pkg;

   localparam int TIMER_BITS    = 16;
   localparam int ROTATION_BITS = 8;

   localparam int STEP_CFG_BITS = 16;
   localparam int ROT_CFG_BITS  = 8;

   localparam int STEP_CMP_BITS = (TIMER_BITS > STEP_CFG_BITS) ? TIMER_BITS : STEP_CFG_BITS;
   localparam int ROT_CMP_BITS  = (ROTATION_BITS > ROT_CFG_BITS) ? ROTATION_BITS : ROT_CFG_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEPS_PER_ROT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_PERIOD     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLOSE_ROT       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_CLOSE_ROT  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPEN_LIMIT_ROT  = 3'd4;

   localparam logic [STEP_CFG_BITS-1:0] RST_STEPS_PER_ROT  = 16'd200;
   localparam logic [STEP_CFG_BITS-1:0] RST_HALF_PERIOD    = 16'd1000;
   localparam logic [ROT_CFG_BITS-1:0]  RST_CLOSE_ROT      = 8'd20;
   localparam logic [ROT_CFG_BITS-1:0]  RST_INIT_CLOSE_ROT = 8'd10;
   localparam logic [ROT_CFG_BITS-1:0]  RST_OPEN_LIMIT_ROT = 8'd151;

   typedef logic [TIMER_BITS-1:0]    timer_type;
   typedef logic [ROTATION_BITS-1:0] rot_type;
   typedef logic [STEP_CMP_BITS-1:0] step_cmp_type;
   typedef logic [ROT_CMP_BITS-1:0]  rot_cmp_type;

   typedef struct packed {
      logic action;
      logic target_open;
      logic sensor_open;
   } req_type;

   typedef struct packed {
      logic step_pulse;
      logic direction_open;
      logic driver_enable;
      logic busy_res;
      logic fault;
      logic curtain_open;
   } rsp_type;

   typedef struct packed {
      logic [STEP_CFG_BITS-1:0] steps_per_rotation;
      logic [STEP_CFG_BITS-1:0] half_period_ticks;
      logic [ROT_CFG_BITS-1:0]  close_rotations;
      logic [ROT_CFG_BITS-1:0]  init_close_rotations;
      logic [ROT_CFG_BITS-1:0]  open_limit_rotations;
   } cfg_type;

endpackage

// File: hdl/limit_seek_stepper_sequencer.sv
// Top level of the limit-seek stepper sequencer: register port, sequencer and result buffer.
// Depends on lss_pkg, lss_core and lss_out_buf.
//
// Each request is either one time tick (action 0) or a target write (action 1) and yields
// exactly one response carrying the step line, direction, driver enable, busy, fault and
// believed curtain state after that request. The sequencer state updates at acceptance and
// the response is registered into the result register, so one request per clock is sustained
// while the result channel keeps up. A one-entry skid stage behind the result register keeps
// req_ready high while a response is stalled; req_ready drops only once both are full.
// Registers are written through the csr_ port, ready at all times; writes to unknown
// indexes are dropped. Step timing is counted in tick requests, not clock cycles.
module limit_seek_stepper_sequencer
   import lss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   rsp_type core_rsp;
   logic    req_accept;
   logic    buf_space;

   assign csr_ready  = 1'b1;
   assign req_ready  = buf_space;
   assign req_accept = req_valid && buf_space;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STEPS_PER_ROT:  cfg_in.steps_per_rotation   = csr_data;
            CSR_HALF_PERIOD:    cfg_in.half_period_ticks    = csr_data;
            CSR_CLOSE_ROT:      cfg_in.close_rotations      = csr_data[ROT_CFG_BITS-1:0];
            CSR_INIT_CLOSE_ROT: cfg_in.init_close_rotations = csr_data[ROT_CFG_BITS-1:0];
            CSR_OPEN_LIMIT_ROT: cfg_in.open_limit_rotations = csr_data[ROT_CFG_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_rotation   <= RST_STEPS_PER_ROT;
         cfg_ff.half_period_ticks    <= RST_HALF_PERIOD;
         cfg_ff.close_rotations      <= RST_CLOSE_ROT;
         cfg_ff.init_close_rotations <= RST_INIT_CLOSE_ROT;
         cfg_ff.open_limit_rotations <= RST_OPEN_LIMIT_ROT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lss_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (req_accept),
      .req     (req_data),
      .cfg     (cfg_ff),
      .rsp     (core_rsp)
   );

   lss_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (core_rsp),
      .space     (buf_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/lss_core.sv
// Sequencer state and next-state logic: start-up, open, close and fault handling.
// Depends on lss_pkg and the assertion macro header.
`include "limit_seek_stepper_sequencer_defines.svh"

module lss_core
   import lss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   localparam logic [2:0] PH_STARTUP    = 3'd0;
   localparam logic [2:0] PH_IDLE       = 3'd1;
   localparam logic [2:0] PH_OPEN       = 3'd2;
   localparam logic [2:0] PH_CLOSE      = 3'd3;
   localparam logic [2:0] PH_INIT_CLOSE = 3'd4;

   function automatic logic is_moving(input logic [2:0] ph);
      return (ph == PH_OPEN) || (ph == PH_CLOSE) || (ph == PH_INIT_CLOSE);
   endfunction

   logic [2:0] phase_ff, phase_in;
   logic       actual_ff, actual_in;
   logic       target_ff, target_in;
   logic       fault_ff, fault_in;
   logic       dir_ff, dir_in;
   logic       pulse_ff, pulse_in;
   timer_type  timer_ff, timer_in;
   timer_type  steps_ff, steps_in;
   rot_type    rot_ff, rot_in;

   timer_type    half_len;
   timer_type    step_inc;
   step_cmp_type spr;
   logic         step_out;

   always_comb begin
      half_len = timer_type'(cfg.half_period_ticks);
      if (half_len == '0) begin
         half_len = timer_type'(1);
      end
      spr = step_cmp_type'(cfg.steps_per_rotation);
      if (spr == '0) begin
         spr = step_cmp_type'(1);
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      actual_in = actual_ff;
      target_in = target_ff;
      fault_in  = fault_ff;
      dir_in    = dir_ff;
      pulse_in  = pulse_ff;
      timer_in  = timer_ff;
      steps_in  = steps_ff;
      rot_in    = rot_ff;
      step_inc  = steps_ff + timer_type'(1);
      step_out  = 1'b0;

      if (req.action) begin
         target_in = req.target_open;
         if (phase_ff == PH_IDLE && !fault_ff && req.target_open != actual_ff) begin
            pulse_in = 1'b0;
            timer_in = '0;
            steps_in = '0;
            rot_in   = '0;
            phase_in = req.target_open ? PH_OPEN : PH_CLOSE;
            dir_in   = req.target_open;
         end
         step_out = is_moving(phase_in) ? pulse_in : 1'b0;
      end else begin
         if (phase_ff == PH_STARTUP) begin
            actual_in = req.sensor_open;
            pulse_in  = 1'b0;
            timer_in  = '0;
            steps_in  = '0;
            rot_in    = '0;
            phase_in  = req.sensor_open ? PH_INIT_CLOSE : PH_OPEN;
            dir_in    = !req.sensor_open;
         end

         // block boundary: line low and no half step pending
         if (is_moving(phase_in) && !pulse_in && timer_in == '0) begin
            if (phase_in == PH_INIT_CLOSE &&
                rot_cmp_type'(rot_in) >= rot_cmp_type'(cfg.init_close_rotations)) begin
               actual_in = target_in;
               pulse_in  = 1'b0;
               timer_in  = '0;
               steps_in  = '0;
               rot_in    = '0;
               phase_in  = PH_OPEN;
               dir_in    = 1'b1;
            end
            if (phase_in == PH_CLOSE) begin
               if (rot_cmp_type'(rot_in) >= rot_cmp_type'(cfg.close_rotations)) begin
                  phase_in  = PH_IDLE;
                  actual_in = target_in;
                  rot_in    = '0;
                  steps_in  = '0;
               end
            end else if (phase_in == PH_OPEN) begin
               if (rot_cmp_type'(rot_in) >= rot_cmp_type'(cfg.open_limit_rotations)) begin
                  fault_in  = 1'b1;
                  phase_in  = PH_IDLE;
                  actual_in = target_in;
                  rot_in    = '0;
                  steps_in  = '0;
               end else if (req.sensor_open) begin
                  phase_in  = PH_IDLE;
                  actual_in = target_in;
                  rot_in    = '0;
                  steps_in  = '0;
               end
            end
            if (is_moving(phase_in)) begin
               pulse_in = 1'b1;
               timer_in = half_len;
            end
         end

         if (is_moving(phase_in)) begin
            step_out = pulse_in;
            step_inc = steps_in + timer_type'(1);
            if (timer_in > timer_type'(1)) begin
               timer_in = timer_in - timer_type'(1);
            end else if (pulse_in) begin
               pulse_in = 1'b0;
               timer_in = half_len;
            end else if (step_cmp_type'(step_inc) >= spr) begin
               steps_in = '0;
               if (rot_in != '1) begin
                  rot_in = rot_in + rot_type'(1);
               end
               timer_in = '0;
            end else begin
               steps_in = step_inc;
               pulse_in = 1'b1;
               timer_in = half_len;
            end
         end
      end
   end

   always_comb begin
      rsp.step_pulse     = step_out;
      rsp.direction_open = dir_in;
      rsp.driver_enable  = is_moving(phase_in);
      rsp.busy_res       = (phase_in != PH_IDLE);
      rsp.fault          = fault_in;
      rsp.curtain_open   = actual_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STARTUP;
         actual_ff <= 1'b0;
         target_ff <= 1'b1;
         fault_ff  <= 1'b0;
         dir_ff    <= 1'b0;
         pulse_ff  <= 1'b0;
         timer_ff  <= '0;
         steps_ff  <= '0;
         rot_ff    <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         actual_ff <= actual_in;
         target_ff <= target_in;
         fault_ff  <= fault_in;
         dir_ff    <= dir_in;
         pulse_ff  <= pulse_in;
         timer_ff  <= timer_in;
         steps_ff  <= steps_in;
         rot_ff    <= rot_in;
      end
   end

   // fault clears only on reset
   `LSS_ASSERT_NEXT(a_fault_sticky, clock, reset, fault_ff, fault_ff)
   // step line is only high during a move
   `LSS_ASSERT_NOW(a_pulse_moving, clock, reset, pulse_ff, is_moving(phase_ff))
   // the first tick always leaves start-up
   `LSS_ASSERT_NEXT(a_startup_leaves, clock, reset,
                    advance && !req.action && phase_ff == PH_STARTUP,
                    phase_ff != PH_STARTUP)

endmodule

// File: hdl/lss_out_buf.sv
// Result register with a one-entry skid stage between the sequencer and the result channel.
// Depends on lss_pkg and the assertion macro header.
`include "limit_seek_stepper_sequencer_defines.svh"

module lss_out_buf
   import lss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;
   logic    load_out;

   assign pop      = out_valid_ff && rsp_ready;
   assign load_out = !out_valid_ff || pop;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (load_out) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space     = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `LSS_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `LSS_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
                    push && out_valid_ff && !pop, skid_valid_ff)
   `LSS_ASSERT_NEXT(a_skid_drains, clock, reset,
                    skid_valid_ff && pop, out_valid_ff && !skid_valid_ff)

endmodule

// File: tb/sv/limit_seek_stepper_sequencer_checker.sv
`timescale 1ns / 100ps
// Response checker for the limit-seek stepper sequencer: follows the register, request and
// response channels, predicts every response and compares it field by field.
// Depends on lss_pkg for the payload structs, register indexes and reset values.
module limit_seek_stepper_sequencer_checker
   import lss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        mismatches,
   output int                        pending_results
);

   typedef enum logic [2:0] {
      SEQ_STARTUP,
      SEQ_IDLE,
      SEQ_OPEN,
      SEQ_CLOSE,
      SEQ_INIT_CLOSE
   } seq_phase_type;

   cfg_type       regs;
   seq_phase_type phase;
   logic          believed_open, wanted_open, fault_latched, dir_line, step_level;
   timer_type     half_left, steps_done;
   rot_type       rotations;
   rsp_type       predicted_outputs[$];

   task automatic report_mismatch(input string what);
      $display("%0t checker: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want)
         report_mismatch($sformatf("%s expected %0b got %0b", name, want, got));
   endtask

   function automatic logic in_motion();
      return phase == SEQ_OPEN || phase == SEQ_CLOSE || phase == SEQ_INIT_CLOSE;
   endfunction

   // a zero half period behaves as one tick
   function automatic timer_type half_ticks();
      return (regs.half_period_ticks == '0) ? timer_type'(1) : timer_type'(regs.half_period_ticks);
   endfunction

   function automatic void clear_motion();
      half_left  = '0;
      steps_done = '0;
      rotations  = '0;
      step_level = 1'b0;
   endfunction

   function automatic void end_move();
      phase         = SEQ_IDLE;
      believed_open = wanted_open;
      clear_motion();
   endfunction

   // drives the current step level for one tick, then advances the half-step timers
   function automatic logic advance_step();
      logic      lvl;
      timer_type per_rot;
      lvl     = step_level;
      per_rot = (regs.steps_per_rotation == '0) ? timer_type'(1)
                                                 : timer_type'(regs.steps_per_rotation);
      if (half_left > 1) begin
         half_left = half_left - 1'b1;
      end else if (step_level) begin
         step_level = 1'b0;
         half_left  = half_ticks();
      end else begin
         steps_done = steps_done + 1'b1;
         if (steps_done >= per_rot) begin
            steps_done = '0;
            if (rotations != '1)
               rotations = rotations + 1'b1;
            half_left = '0;
         end else begin
            step_level = 1'b1;
            half_left  = half_ticks();
         end
      end
      return lvl;
   endfunction

   function automatic rsp_type next_outputs(input req_type r);
      rsp_type o;
      logic    step_out;
      step_out = 1'b0;
      if (r.action) begin
         wanted_open = r.target_open;
         if (phase == SEQ_IDLE && !fault_latched && wanted_open != believed_open) begin
            clear_motion();
            if (wanted_open)
               phase = SEQ_OPEN;
            else
               phase = SEQ_CLOSE;
            dir_line = wanted_open;
         end
         step_out = in_motion() ? step_level : 1'b0;
      end else begin
         if (phase == SEQ_STARTUP) begin
            believed_open = r.sensor_open;
            clear_motion();
            if (r.sensor_open)
               phase = SEQ_INIT_CLOSE;
            else
               phase = SEQ_OPEN;
            dir_line = !r.sensor_open;
         end
         // block boundary: step line low, no half step pending
         if (in_motion() && !step_level && half_left == '0) begin
            if (phase == SEQ_INIT_CLOSE && rotations >= regs.init_close_rotations) begin
               believed_open = wanted_open;
               clear_motion();
               phase    = SEQ_OPEN;
               dir_line = 1'b1;
            end
            if (phase == SEQ_CLOSE) begin
               if (rotations >= regs.close_rotations)
                  end_move();
            end else if (phase == SEQ_OPEN) begin
               // the rotation limit wins over the sensor
               if (rotations >= regs.open_limit_rotations) begin
                  fault_latched = 1'b1;
                  end_move();
               end else if (r.sensor_open) begin
                  end_move();
               end
            end
            if (in_motion()) begin
               step_level = 1'b1;
               half_left  = half_ticks();
            end
         end
         if (in_motion())
            step_out = advance_step();
      end
      o.step_pulse     = step_out;
      o.direction_open = dir_line;
      o.driver_enable  = in_motion();
      o.busy_res       = phase != SEQ_IDLE;
      o.fault          = fault_latched;
      o.curtain_open   = believed_open;
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         regs.steps_per_rotation   = RST_STEPS_PER_ROT;
         regs.half_period_ticks    = RST_HALF_PERIOD;
         regs.close_rotations      = RST_CLOSE_ROT;
         regs.init_close_rotations = RST_INIT_CLOSE_ROT;
         regs.open_limit_rotations = RST_OPEN_LIMIT_ROT;
         phase         = SEQ_STARTUP;
         believed_open = 1'b0;
         wanted_open   = 1'b1;
         fault_latched = 1'b0;
         dir_line      = 1'b0;
         clear_motion();
         predicted_outputs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STEPS_PER_ROT:  regs.steps_per_rotation   = csr_data;
               CSR_HALF_PERIOD:    regs.half_period_ticks    = csr_data;
               CSR_CLOSE_ROT:      regs.close_rotations      = csr_data[ROT_CFG_BITS-1:0];
               CSR_INIT_CLOSE_ROT: regs.init_close_rotations = csr_data[ROT_CFG_BITS-1:0];
               CSR_OPEN_LIMIT_ROT: regs.open_limit_rotations = csr_data[ROT_CFG_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = predicted_outputs.pop_front();
               check_field("step_pulse", want.step_pulse, rsp_data.step_pulse);
               check_field("direction_open", want.direction_open, rsp_data.direction_open);
               check_field("driver_enable", want.driver_enable, rsp_data.driver_enable);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("fault", want.fault, rsp_data.fault);
               check_field("curtain_open", want.curtain_open, rsp_data.curtain_open);
            end
         end
         if (req_valid && req_ready)
            predicted_outputs.push_back(next_outputs(req_data));
      end
      pending_results = predicted_outputs.size();
   end

endmodule

// File: tb/sv/limit_seek_stepper_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the limit-seek stepper sequencer: clock, reset, request and register
// stimulus with random idling, and the verdict. Depends on lss_pkg, the block and the checker.
module limit_seek_stepper_sequencer_tb;
   import lss_pkg::*;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam logic ACT_TICK       = 1'b0;
   localparam logic ACT_SET_TARGET = 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_FIRST = 3'd5;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        mismatches;
   int                        pending_results;
   int                        req_idle_pct;
   int                        rsp_stall_pct;

   limit_seek_stepper_sequencer dut (.*);

   limit_seek_stepper_sequencer_checker seq_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            req_idle_pct  = 65;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 65;
         end
         default: begin
            req_idle_pct  = 9;
            rsp_stall_pct = 9;
         end
      endcase
   endtask

   // entered and left at a falling edge; valid stays high for a back-to-back request
   task automatic send_request(input logic action, input logic target, input logic sensor);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{action: action, target_open: target, sensor_open: sensor};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic tick(input logic sensor);
      send_request(ACT_TICK, 1'($urandom_range(1)), sensor);
   endtask

   task automatic set_target(input logic open_wanted);
      send_request(ACT_SET_TARGET, open_wanted, 1'($urandom_range(1)));
   endtask

   task automatic run_ticks(input int count, input int one_pct);
      for (int i = 0; i < count; i++)
         tick($urandom_range(99) < one_pct);
   endtask

   task automatic mixed_traffic(input int count, input int write_pct, input int one_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < write_pct)
            set_target(1'($urandom_range(1)));
         else
            tick($urandom_range(99) < one_pct);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] reg_index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // 8-bit registers: random upper byte, which the block drops
   function automatic logic [CSR_DATA_BITS-1:0] with_noise_byte(input int value);
      return {8'($urandom_range(255)), 8'(value)};
   endfunction

   task automatic write_random_config();
      write_register(CSR_STEPS_PER_ROT,
                     ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
      write_register(CSR_HALF_PERIOD,
                     ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 3)));
      write_register(CSR_CLOSE_ROT, with_noise_byte($urandom_range(4)));
      write_register(CSR_INIT_CLOSE_ROT, with_noise_byte($urandom_range(255)));
      // high enough that sensor hits stop an open move long before the limit
      write_register(CSR_OPEN_LIMIT_ROT, with_noise_byte($urandom_range(40, 255)));
      if ($urandom_range(3) == 0)
         write_register(CSR_UNUSED_FIRST + 3'($urandom_range(2)), 16'($urandom));
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: short blocks, start-up chain, retarget, same-target write
      set_idling(IDLE_NONE);
      write_register(CSR_UNUSED_FIRST, 16'hFFFF);
      write_register(CSR_STEPS_PER_ROT, 16'd2);
      write_register(CSR_HALF_PERIOD, 16'd1);
      write_register(CSR_CLOSE_ROT, with_noise_byte(1));
      write_register(CSR_INIT_CLOSE_ROT, with_noise_byte($urandom_range(2)));
      write_register(CSR_OPEN_LIMIT_ROT, with_noise_byte(255));
      set_target(1'($urandom_range(1)));
      tick(1'($urandom_range(3) != 0));
      run_ticks(10, 0);
      set_target(1'b1);
      run_ticks(10, 100);
      set_target(1'b0);
      set_target(1'b0);
      run_ticks(3, 50);

      for (int ph = 0; ph < 6; ph++) begin
         set_idling(idle_mode_type'(ph % 4));
         write_random_config();
         mixed_traffic(30, 12, $urandom_range(25, 60));
      end

      // longest close move: settle open first, then close 255 blocks
      set_idling(idle_mode_type'($urandom_range(3)));
      write_register(CSR_STEPS_PER_ROT, 16'd1);
      write_register(CSR_HALF_PERIOD, 16'd1);
      set_target(1'b1);
      run_ticks(20, 100);
      write_register(CSR_CLOSE_ROT, with_noise_byte(255));
      write_register(CSR_INIT_CLOSE_ROT, with_noise_byte(0));
      set_target(1'b0);
      run_ticks(530, 50);

      // widest rotation block, cut short by a smaller count mid-move
      set_idling(IDLE_BOTH);
      write_register(CSR_HALF_PERIOD, 16'd0);
      write_register(CSR_STEPS_PER_ROT, 16'hFFFF);
      set_target(1'b1);
      run_ticks(80, 50);
      write_register(CSR_STEPS_PER_ROT, 16'd2);
      mixed_traffic(40, 15, 40);

      // fault: small open limit, sensor mostly low; the fault stays latched
      set_idling(IDLE_SENDER);
      write_register(CSR_STEPS_PER_ROT, 16'($urandom_range(1, 3)));
      write_register(CSR_HALF_PERIOD, 16'($urandom_range(1, 2)));
      write_register(CSR_CLOSE_ROT, with_noise_byte($urandom_range(2)));
      write_register(CSR_OPEN_LIMIT_ROT, with_noise_byte($urandom_range(3)));
      repeat (2) begin
         set_target(1'b0);
         run_ticks(50, 100);
         set_target(1'b1);
         run_ticks(50, 20);
      end

      set_idling(IDLE_RECEIVER);
      write_register(CSR_STEPS_PER_ROT, 16'hFFFF);
      write_register(CSR_HALF_PERIOD, 16'hFFFF);
      write_register(CSR_CLOSE_ROT, 16'hFFFF);
      write_register(CSR_INIT_CLOSE_ROT, 16'hFFFF);
      write_register(CSR_OPEN_LIMIT_ROT, 16'hFFFF);
      write_register(CSR_UNUSED_FIRST + 3'($urandom_range(2)), 16'($urandom));
      mixed_traffic(40, 40, 50);

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && pending_results == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
